@@ hw/rtl/amtd_pkg.sv @@
`default_nettype none
package amtd_pkg;
  localparam logic [1:0] MODE_EDGE  = 2'd0;
  localparam logic [1:0] MODE_POLL  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [0:0] REG_SAMPLES_PER_MS = 1'd0;
  localparam logic [0:0] REG_INITIAL_DIT    = 1'd1;

  localparam logic [9:0] SPMS_DEFAULT = 10'd48;
  localparam logic [7:0] DIT_DEFAULT  = 8'd60;
  localparam logic [7:0] DIT_MIN      = 8'd15;
  localparam logic [7:0] DIT_MAX      = 8'd240;
  localparam logic [6:0] CH_UNKNOWN   = 7'd63;
  localparam logic [6:0] CH_SPACE     = 7'd32;

  // Map a sentinel-prefixed code to ASCII, zero where no character exists
  function automatic logic [6:0] morse_char(input logic [5:0] code);
    logic [6:0] c;
    begin
      c = 7'd0;
      case (code)
        6'd2:  c = 7'h45; 6'd3:  c = 7'h54;
        6'd4:  c = 7'h49; 6'd5:  c = 7'h41; 6'd6:  c = 7'h4E; 6'd7:  c = 7'h4D;
        6'd8:  c = 7'h53; 6'd9:  c = 7'h55; 6'd10: c = 7'h52; 6'd11: c = 7'h57;
        6'd12: c = 7'h44; 6'd13: c = 7'h4B; 6'd14: c = 7'h47; 6'd15: c = 7'h4F;
        6'd16: c = 7'h48; 6'd17: c = 7'h56; 6'd18: c = 7'h46; 6'd20: c = 7'h4C;
        6'd22: c = 7'h50; 6'd23: c = 7'h4A; 6'd24: c = 7'h42; 6'd25: c = 7'h58;
        6'd26: c = 7'h43; 6'd27: c = 7'h59; 6'd28: c = 7'h5A; 6'd29: c = 7'h51;
        6'd32: c = 7'h35; 6'd33: c = 7'h34; 6'd35: c = 7'h33; 6'd39: c = 7'h32;
        6'd42: c = 7'h2B; 6'd47: c = 7'h31; 6'd48: c = 7'h36; 6'd49: c = 7'h3D;
        6'd50: c = 7'h2F; 6'd56: c = 7'h37; 6'd60: c = 7'h38; 6'd62: c = 7'h39;
        6'd63: c = 7'h30;
        default: c = 7'd0;
      endcase
      return c;
    end
  endfunction

  function automatic logic [7:0] clamp_dit(input logic [9:0] v);
    begin
      if (v < 10'(DIT_MIN)) return DIT_MIN;
      if (v > 10'(DIT_MAX)) return DIT_MAX;
      return v[7:0];
    end
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/amtd_if.sv @@
`default_nettype none
interface amtd_in_if #(parameter int TIME_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic                 key_level;
  logic [TIME_BITS-1:0] sample_time;
  modport source (output valid, mode, key_level, sample_time, input ready);
  modport sink   (input valid, mode, key_level, sample_time, output ready);
endinterface

interface amtd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last;
  modport source (output valid, char_code, last, input ready);
  modport sink   (input valid, char_code, last, output ready);
endinterface

interface amtd_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [9:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/adaptive_morse_timing_decoder.sv @@
`default_nettype none
// Adaptive Morse timing decoder. Each request is a keying edge, poll tick or
// clear; it yields zero to two characters (decoded letter, '?' or word space),
// the final one flagged by last. Spans are converted to ms by one shared serial
// divider at one bit per cycle. Input ready is low while a request is at work:
// a clear, a repeated level, a falling edge or an ignored mode is only decided;
// a dropout that rejoins the held element takes one division; a rising edge or
// poll that only checks the gap takes one division and then hands out its
// results; and up to three divisions come before the results when a held
// element is settled first. Ready stays low while results stall. Registers
// are taken only while the block is idle; no clearing pass follows reset.
module adaptive_morse_timing_decoder
  import amtd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  amtd_in_if.sink   in_ch,
  amtd_out_if.source out_ch,
  amtd_cfg_if.sink  cfg
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECIDE = 9'b000000010,
    S_DIV1   = 9'b000000100,
    S_USE1   = 9'b000001000,
    S_DIV2   = 9'b000010000,
    S_USE2   = 9'b000100000,
    S_GAP    = 9'b001000000,
    S_OUT    = 9'b010000000,
    S_ADAPT  = 9'b100000000
  } state_t;

  state_t state;
  logic [9:0]           spms;
  logic                 key_down, element_pending, char_finished, word_finished;
  logic [TIME_BITS-1:0] rise_time, fall_time, prise, pfall;
  logic [5:0]           code_bits;
  logic [7:0]           dit;
  // request latch
  logic [1:0]           mode;
  logic                 level;
  logic [TIME_BITS-1:0] t;
  // divider
  logic                 div_start, div_done;
  logic [TIME_BITS-1:0] div_a;
  logic [15:0]          q;
  logic [15:0]          dur;
  // results
  logic [6:0]           res0, res1;
  logic [1:0]           nres;
  logic                 ridx;

  amtd_div #(.TIME_BITS(TIME_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(spms), .done(div_done), .quotient(q)
  );

  assign in_ch.ready   = (state == S_IDLE);
  assign cfg.ready     = (state == S_IDLE);
  assign out_ch.valid  = (state == S_OUT) && (nres != 2'd0);
  assign out_ch.char_code = ridx ? res1 : res0;
  assign out_ch.last   = (2'(ridx) + 2'd1 == nres);

  logic [15:0] quarter, two_dit, five_dit, eight_dit;
  assign quarter   = 16'(dit[7:2]);
  assign two_dit   = {7'd0, dit, 1'b0};
  assign five_dit  = 16'(dit) * 16'd5;
  assign eight_dit = {5'd0, dit, 3'd0};

  // dit adaptation for element dur (dur <= 8*dit here)
  logic        dah;
  logic [21:0] third_prod;
  logic [11:0] est;
  logic [11:0] avg;
  logic [6:0]  gc_ch;
  assign dah = dur > two_dit;
  // dur/3 as (dur*683)>>11, exact for dur below 2048
  assign third_prod = 22'(dur[11:0]) * 22'd683;
  assign est = dah ? 12'(third_prod >> 11) : dur[11:0];
  assign avg = (est < 12'(dit)) ? 12'((13'(dit) + 13'(est)) >> 1)
                                : 12'((13'(dit) * 13'd7 + 13'(est)) >> 3);
  assign gc_ch = morse_char(code_bits);

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      spms <= SPMS_DEFAULT;
      dit <= DIT_DEFAULT;
      key_down <= 1'b0; element_pending <= 1'b0;
      char_finished <= 1'b0; word_finished <= 1'b0;
      rise_time <= '0; fall_time <= '0; prise <= '0; pfall <= '0;
      code_bits <= 6'd1; nres <= '0; ridx <= 1'b0;
    end else begin
      // take register writes while idle
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_SAMPLES_PER_MS) spms <= cfg.data;
        else dit <= clamp_dit({2'd0, cfg.data[7:0]});
      end
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          mode <= in_ch.mode; level <= in_ch.key_level; t <= in_ch.sample_time;
          nres <= '0; ridx <= 1'b0; state <= S_DECIDE;
        end
        S_DECIDE: begin
          state <= S_IDLE;
          case (mode)
            MODE_EDGE: begin
              if (level == key_down) begin
                if (level) rise_time <= t; else fall_time <= t;
              end else if (!level) begin
                prise <= rise_time; pfall <= t;
                element_pending <= 1'b1; key_down <= 1'b0;
              end else if (element_pending) begin
                div_a <= t - pfall; div_start <= 1'b1; state <= S_DIV1;
              end else begin
                div_a <= t - fall_time; div_start <= 1'b1; state <= S_DIV2;
              end
            end
            MODE_POLL: if (!key_down) begin
              if (element_pending) begin
                div_a <= t - pfall; div_start <= 1'b1; state <= S_DIV1;
              end else begin
                div_a <= t - fall_time; div_start <= 1'b1; state <= S_DIV2;
              end
            end
            MODE_CLEAR: begin
              key_down <= 1'b0; rise_time <= t; fall_time <= t;
              element_pending <= 1'b0; code_bits <= 6'd1;
              char_finished <= 1'b0; word_finished <= 1'b0;
            end
            default: ;
          endcase
        end
        // gap since pending fall: dropout, or settle the element
        S_DIV1: if (div_done) begin
          if (q < quarter) begin
            if (mode == MODE_EDGE) begin
              rise_time <= prise; element_pending <= 1'b0; key_down <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            div_a <= pfall - prise; div_start <= 1'b1; state <= S_USE1;
          end
        end
        // element length ready
        S_USE1: if (div_done) begin
          dur <= q;
          element_pending <= 1'b0;
          if (q < quarter) begin
            state <= S_DIV2;
            div_a <= t - fall_time; div_start <= 1'b1;
          end else if (q > eight_dit) begin
            code_bits <= 6'd1; fall_time <= pfall;
            char_finished <= 1'b1; word_finished <= 1'b1;
            state <= S_DIV2;
            div_a <= t - pfall; div_start <= 1'b1;
          end else begin
            state <= S_ADAPT;
          end
        end
        S_ADAPT: begin
          dit <= clamp_dit(10'(avg));
          code_bits <= (code_bits < 6'd32) ? {code_bits[4:0], dah} : 6'd1;
          fall_time <= pfall; char_finished <= 1'b0; word_finished <= 1'b0;
          div_a <= t - pfall; div_start <= 1'b1; state <= S_DIV2;
        end
        S_DIV2: if (div_done) begin
          dur <= q; state <= S_GAP;
        end
        // character end, then word space
        S_GAP: begin
          state <= S_USE2;
          if (!char_finished && code_bits > 6'd1 && dur >= two_dit) begin
            res0 <= (gc_ch != 7'd0) ? gc_ch : CH_UNKNOWN;
            nres <= 2'd1; code_bits <= 6'd1; char_finished <= 1'b1;
          end
        end
        S_USE2: begin
          if (char_finished && !word_finished && dur >= five_dit) begin
            if (nres == 2'd0) res0 <= CH_SPACE; else res1 <= CH_SPACE;
            nres <= nres + 2'd1; word_finished <= 1'b1;
          end
          if (mode == MODE_EDGE) begin
            rise_time <= t; key_down <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (nres == 2'd0) state <= S_IDLE;
          else if (out_ch.ready) begin
            if (out_ch.last) state <= S_IDLE;
            ridx <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_dit_range: assert property (@(posedge clk) disable iff (rst)
    dit >= DIT_MIN && dit <= DIT_MAX) else $error("dit out of range");
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_code_nonzero: assert property (@(posedge clk) disable iff (rst)
    code_bits != 6'd0) else $error("code lost sentinel");
  a_out_count: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> nres != 2'd3) else $error("too many results");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/amtd_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle; quotient saturates to 16 bits
module amtd_div
  import amtd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [TIME_BITS-1:0] dividend,
  input  wire logic [9:0]           divisor,
  output logic                      done,
  output logic [15:0]               quotient
);
  localparam int CW = $clog2(TIME_BITS + 1);
  logic [TIME_BITS-1:0] num;
  logic [TIME_BITS-1:0] quo;
  logic [63:0]          quo_wide;
  logic [9:0]           rem;
  logic [9:0]           dvs;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic [10:0]          trial;

  assign trial = {rem, num[TIME_BITS-1]};
  // Saturate: callers only compare against values below 2^16
  assign quo_wide = 64'(quo);
  assign quotient = (quo_wide[63:16] != '0) ? 16'hFFFF : quo_wide[15:0];

  // Shift one dividend bit in per cycle
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      num  <= dividend;
      dvs  <= (divisor == 10'd0) ? SPMS_DEFAULT : divisor;
      rem  <= '0;
      quo  <= '0;
      cnt  <= CW'(TIME_BITS);
    end else if (busy) begin
      num <= {num[TIME_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem <= 10'(trial - {1'b0, dvs});
        quo <= {quo[TIME_BITS-2:0], 1'b1};
      end else begin
        rem <= trial[9:0];
        quo <= {quo[TIME_BITS-2:0], 1'b0};
      end
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ test/amtd_checker.sv @@
// Watches the request, result and register channels, keeps its own copy of the
// decoder state and checks every character that comes out.
module amtd_checker
  import amtd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  amtd_in_if   in_ch,
  amtd_out_if  out_ch,
  amtd_cfg_if  cfg,
  output int   fail_count,
  output int   chars_waiting
);

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } char_t;

  char_t expected_chars[$];

  logic [9:0]  spms;
  logic [7:0]  init_dit;
  logic        key_down;
  logic [31:0] rise_t, fall_t, pend_rise_t, pend_fall_t;
  logic        elem_pending;
  logic [5:0]  code;
  logic        char_done, word_closed;
  int unsigned dit;
  char_t       new_chars[2];
  int          n_new;

  function automatic int unsigned limit_dit(longint unsigned v);
    if (v < DIT_MIN) return DIT_MIN;
    if (v > DIT_MAX) return DIT_MAX;
    return int'(v);
  endfunction

  function automatic logic [31:0] to_ms(logic [31:0] later, logic [31:0] earlier);
    logic [31:0] d;
    logic [31:0] div;
    d = later - earlier;
    div = (spms == 10'd0) ? 32'(SPMS_DEFAULT) : 32'(spms);
    return d / div;
  endfunction

  function automatic logic [6:0] lookup(logic [5:0] c);
    logic [7:0] ch;
    case (c)
      6'd2: ch = "E"; 6'd3: ch = "T"; 6'd4: ch = "I"; 6'd5: ch = "A";
      6'd6: ch = "N"; 6'd7: ch = "M"; 6'd8: ch = "S"; 6'd9: ch = "U";
      6'd10: ch = "R"; 6'd11: ch = "W"; 6'd12: ch = "D"; 6'd13: ch = "K";
      6'd14: ch = "G"; 6'd15: ch = "O"; 6'd16: ch = "H"; 6'd17: ch = "V";
      6'd18: ch = "F"; 6'd20: ch = "L"; 6'd22: ch = "P"; 6'd23: ch = "J";
      6'd24: ch = "B"; 6'd25: ch = "X"; 6'd26: ch = "C"; 6'd27: ch = "Y";
      6'd28: ch = "Z"; 6'd29: ch = "Q"; 6'd32: ch = "5"; 6'd33: ch = "4";
      6'd35: ch = "3"; 6'd39: ch = "2"; 6'd42: ch = "+"; 6'd47: ch = "1";
      6'd48: ch = "6"; 6'd49: ch = "="; 6'd50: ch = "/"; 6'd56: ch = "7";
      6'd60: ch = "8"; 6'd62: ch = "9"; 6'd63: ch = "0";
      default: ch = 8'd0;
    endcase
    return ch[6:0];
  endfunction

  task automatic emit(logic [6:0] ch);
    if (n_new < 2) begin
      new_chars[n_new] = '{char_code: ch, last: 1'b0};
      n_new++;
    end
  endtask

  // Close a character at two dits of silence, a word at five
  task automatic check_gap(logic [31:0] gap);
    logic [6:0] ch;
    if (!char_done && code > 6'd1 && 64'(gap) >= 64'(dit) * 2) begin
      ch = lookup(code);
      emit((ch != 7'd0) ? ch : CH_UNKNOWN);
      code = 6'd1;
      char_done = 1'b1;
    end
    if (char_done && !word_closed && 64'(gap) >= 64'(dit) * 5) begin
      emit(CH_SPACE);
      word_closed = 1'b1;
    end
  endtask

  // Adapt the dit estimate and shift the element into the code
  task automatic add_element(logic [31:0] dur);
    logic dah;
    longint unsigned est;
    dah = 64'(dur) > 64'(dit) * 2;
    est = dah ? 64'(dur) / 3 : 64'(dur);
    if (est < dit) dit = limit_dit((dit + est) / 2);
    else dit = limit_dit((64'(dit) * 7 + est) / 8);
    if (code < 6'd32) code = {code[4:0], dah};
    else code = 6'd1;
  endtask

  // Resolve the held element: blip, steady carrier or real element
  task automatic resolve_pending();
    logic [31:0] dur;
    dur = to_ms(pend_fall_t, pend_rise_t);
    elem_pending = 1'b0;
    if (dur < dit / 4) begin
    end else if (64'(dur) > 64'(dit) * 8) begin
      code = 6'd1;
      fall_t = pend_fall_t;
      char_done = 1'b1;
      word_closed = 1'b1;
    end else begin
      add_element(dur);
      fall_t = pend_fall_t;
      char_done = 1'b0;
      word_closed = 1'b0;
    end
  endtask

  task automatic predict(logic [1:0] mode, logic level, logic [31:0] t);
    n_new = 0;
    case (mode)
      MODE_EDGE: begin
        if (level == key_down) begin
          if (level) rise_t = t; else fall_t = t;
        end else if (level) begin
          if (elem_pending && to_ms(t, pend_fall_t) < dit / 4) begin
            rise_t = pend_rise_t;
            elem_pending = 1'b0;
          end else begin
            if (elem_pending) resolve_pending();
            check_gap(to_ms(t, fall_t));
            rise_t = t;
          end
          key_down = 1'b1;
        end else begin
          pend_rise_t = rise_t;
          pend_fall_t = t;
          elem_pending = 1'b1;
          key_down = 1'b0;
        end
      end
      MODE_POLL: begin
        if (!key_down) begin
          if (elem_pending && to_ms(t, pend_fall_t) >= dit / 4) resolve_pending();
          if (!elem_pending) check_gap(to_ms(t, fall_t));
        end
      end
      MODE_CLEAR: begin
        key_down = 1'b0;
        rise_t = t;
        fall_t = t;
        elem_pending = 1'b0;
        code = 6'd1;
        char_done = 1'b0;
        word_closed = 1'b0;
      end
      default: ;
    endcase
    if (n_new > 0) new_chars[n_new-1].last = 1'b1;
    for (int i = 0; i < n_new; i++) expected_chars.push_back(new_chars[i]);
  endtask

  always @(posedge clk) begin
    char_t want;
    if (rst) begin
      spms = SPMS_DEFAULT;
      init_dit = DIT_DEFAULT;
      key_down = 1'b0;
      rise_t = '0;
      fall_t = '0;
      pend_rise_t = '0;
      pend_fall_t = '0;
      elem_pending = 1'b0;
      code = 6'd1;
      char_done = 1'b0;
      word_closed = 1'b0;
      dit = DIT_DEFAULT;
      expected_chars.delete();
      fail_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_SAMPLES_PER_MS) begin
          spms = cfg.data;
        end else begin
          init_dit = cfg.data[7:0];
          dit = limit_dit(init_dit);
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict(in_ch.mode, in_ch.key_level, in_ch.sample_time);
      // Compare each taken character with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character: char_code %0d last %0b",
                 out_ch.char_code, out_ch.last);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.char_code !== want.char_code) begin
            $error("char_code: expected %0d, got %0d", want.char_code, out_ch.char_code);
            fail_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            fail_count++;
          end
        end
      end
    end
    chars_waiting = expected_chars.size();
  end

endmodule

@@ test/adaptive_morse_timing_decoder_tb.sv @@
module adaptive_morse_timing_decoder_tb;
  import amtd_pkg::*;

  localparam int STALL_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   chars_waiting;
  int   requests_sent = 0;
  int   idle_cycles = 0;
  bit   calm = 1'b0;
  bit   hold_started = 1'b0;
  int   hold_left = 0;
  logic [31:0] now;
  int unsigned cur_spms;

  amtd_in_if #(.TIME_BITS(32)) in_ch();
  amtd_out_if out_ch();
  amtd_cfg_if cfg_ch();

  adaptive_morse_timing_decoder #(.TIME_BITS(32)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg_ch)
  );

  amtd_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg_ch),
    .fail_count(fail_count), .chars_waiting(chars_waiting)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_EDGE;
    in_ch.key_level = 1'b0;
    in_ch.sample_time = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_SAMPLES_PER_MS;
    cfg_ch.data = '0;
  end

  // Receiver: random stalls, one long hold-off once traffic is flowing
  always @(posedge clk) begin
    if (!hold_started && requests_sent >= 200) begin
      hold_started <= 1'b1;
      hold_left <= 500;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 23);
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offer one request and hold it until taken
  task automatic send(logic [1:0] mode, logic level, logic [31:0] t);
    bit taken;
    if (!calm && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.key_level <= level;
    in_ch.sample_time <= t;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
    requests_sent++;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [9:0] value);
    bit taken;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do begin
      @(negedge clk);
      taken = cfg_ch.ready;
      @(posedge clk);
    end while (!taken);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drain all predicted characters, then let the block settle
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (chars_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Advance time by a span in ms plus a sub-ms remainder
  task automatic advance(int unsigned ms);
    now = now + 32'(ms * cur_spms + $urandom_range(0, cur_spms - 1));
  endtask

  // Key one element then leave a gap, polling inside the gap now and then
  task automatic key_element(int unsigned on_ms, int unsigned off_ms);
    send(MODE_EDGE, 1'b1, now);
    advance(on_ms);
    send(MODE_EDGE, 1'b0, now);
    if ($urandom_range(3) == 0) begin
      advance(off_ms / 2);
      send(MODE_POLL, 1'b0, now);
      advance(off_ms - off_ms / 2);
    end else begin
      advance(off_ms);
    end
    if ($urandom_range(2) == 0) send(MODE_POLL, 1'b0, now);
  endtask

  // Key one character of given dah pattern with element count n
  task automatic key_char(int unsigned d, int unsigned n, logic [5:0] pattern,
                          int unsigned end_gap);
    int unsigned on_ms;
    for (int i = 0; i < n; i++) begin
      on_ms = pattern[i] ? 3 * d : d;
      on_ms = on_ms + $urandom_range(0, d / 4);
      key_element(on_ms, (i == n - 1) ? end_gap : d + $urandom_range(0, d / 4));
    end
  endtask

  // Mostly clean keying with random characters, some noise and broken timing
  task automatic random_traffic(int unsigned count);
    int unsigned d;
    int unsigned stop_at;
    int unsigned kind;
    stop_at = requests_sent + count;
    d = $urandom_range(20, 180);
    while (requests_sent < stop_at) begin
      if (!calm && requests_sent > 450 && requests_sent < 600) calm = 1'b1;
      else if (calm && requests_sent >= 600) calm = 1'b0;
      kind = $urandom_range(99);
      if (kind < 70) begin
        key_char(d, $urandom_range(1, 6), 6'($urandom),
                 ($urandom_range(2) == 0) ? 7 * d + $urandom_range(0, d) : 3 * d);
      end else if (kind < 76) begin
        key_element($urandom_range(1, d / 5 + 1), d);
      end else if (kind < 82) begin
        send(MODE_EDGE, 1'b1, now);
        advance(d);
        send(MODE_EDGE, 1'b0, now);
        advance($urandom_range(0, d / 5));
        send(MODE_EDGE, 1'b1, now);
        advance(d);
        send(MODE_EDGE, 1'b0, now);
        advance(3 * d);
        send(MODE_POLL, 1'b0, now);
      end else if (kind < 85) begin
        key_element(9 * d + $urandom_range(0, 4 * d), 6 * d);
      end else if (kind < 88) begin
        send(MODE_CLEAR, 1'($urandom_range(1)), now);
      end else if (kind < 91) begin
        d = $urandom_range(15, 240);
      end else if (kind < 94) begin
        now = $urandom;
        send(MODE_POLL, 1'($urandom_range(1)), now);
      end else begin
        send(2'($urandom_range(3)), 1'($urandom_range(1)), $urandom);
        now = now + $urandom_range(0, 50000);
      end
    end
  endtask

  task automatic run_phase(logic [9:0] spms_val, logic [9:0] dit_val, int unsigned count);
    write_reg(REG_SAMPLES_PER_MS, spms_val);
    write_reg(REG_INITIAL_DIT, dit_val);
    cur_spms = (spms_val == 0) ? 48 : spms_val;
    send(MODE_CLEAR, 1'b0, now);
    random_traffic(count);
    settle();
  endtask

  initial begin
    now = 32'hFFFF_0000;
    cur_spms = 48;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: ignored mode, repeated levels, wrap of time, extremes
    send(2'd3, 1'b1, 32'hFFFF_FFFF);
    send(MODE_EDGE, 1'b0, 32'h0000_0000);
    send(MODE_EDGE, 1'b1, now);
    send(MODE_EDGE, 1'b1, now + 32'd10);
    now = now + 32'd3000;
    send(MODE_EDGE, 1'b0, now);
    send(MODE_EDGE, 1'b0, now + 32'd5);
    advance(200);
    send(MODE_POLL, 1'b1, now);
    // Unknown code, sixth element, blip, carrier and a word space
    key_char(60, 4, 6'b001100, 180);
    key_char(60, 6, 6'b101010, 180);
    key_element(5, 60);
    key_element(700, 400);
    key_char(60, 1, 6'b000000, 500);
    send(MODE_CLEAR, 1'b1, 32'hFFFF_FFFF);
    now = 32'hFFFF_FF00;
    key_char(60, 2, 6'b000010, 450);
    settle();

    run_phase(10'd0, 10'd15, 180);
    run_phase(10'd1023, 10'd240, 180);
    run_phase(10'd1, 10'd255, 180);
    run_phase(10'd7, 10'd5, 180);
    run_phase(10'd200, 10'd100, 180);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ adaptive_morse_timing_decoder.f @@
hw/rtl/amtd_pkg.sv
hw/rtl/amtd_if.sv
hw/rtl/amtd_div.sv
hw/rtl/adaptive_morse_timing_decoder.sv
test/amtd_checker.sv
test/adaptive_morse_timing_decoder_tb.sv
